>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Simulation builds get concurrent
// assertions that report through $error; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

>>> rtl/qcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qcf_pkg;

   // Field widths fixed by the interface.
   localparam int FIELD_W = 12;
   localparam int THRESH_W = 13;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 13'd5;

   // Defaults for the top-level parameters.
   localparam int MAX_DEPTH_DEF = 6;
   localparam int COORD_BITS_DEF = 12;

   // Number of coordinates that describe one half curve.
   localparam int NUM_COORDS = 6;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_EMIT,
      ST_POP,
      ST_LOAD
   } state_type;

   // Control group from the sequencer to the datapath and the stack.
   typedef struct packed {
      logic req_ready;
      logic rsp_valid;
      logic load_in;
      logic load_split;
      logic push;
      logic pop;
      logic load_pop;
   } ctrl_type;

endpackage

`default_nettype wire

>>> rtl/qcf_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface qcf_req_if
   import qcf_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] start_x;
   logic [FIELD_W-1:0] start_y;
   logic [FIELD_W-1:0] control_x;
   logic [FIELD_W-1:0] control_y;
   logic [FIELD_W-1:0] end_x;
   logic [FIELD_W-1:0] end_y;

   modport source (
      output valid, start_x, start_y, control_x, control_y, end_x, end_y,
      input  ready
   );

   modport sink (
      input  valid, start_x, start_y, control_x, control_y, end_x, end_y,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/qcf_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface qcf_rsp_if
   import qcf_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] seg_from_x;
   logic [FIELD_W-1:0] seg_from_y;
   logic [FIELD_W-1:0] seg_to_x;
   logic [FIELD_W-1:0] seg_to_y;
   logic               final_segment;

   modport source (
      output valid, seg_from_x, seg_from_y, seg_to_x, seg_to_y, final_segment,
      input  ready
   );

   modport sink (
      input  valid, seg_from_x, seg_from_y, seg_to_x, seg_to_y, final_segment,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/qcf_split_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared split and flatness unit. Coordinate order in a half:
// x0, y0, x1, y1, x2, y2.
module qcf_split_unit
   import qcf_pkg::*;
#(
   parameter int CW = COORD_BITS_DEF
) (
   input  wire logic [NUM_COORDS-1:0][CW-1:0] cur_pts,
   input  wire logic [THRESH_W-1:0]           threshold,
   output logic      [NUM_COORDS-1:0][CW-1:0] lo_pts,
   output logic      [NUM_COORDS-1:0][CW-1:0] hi_pts,
   output logic                               flat
);

   function automatic logic [CW-1:0] mid(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CW:1];
   endfunction

   function automatic logic [CW-1:0] absdiff(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [CW-1:0]       ax, ay, cx, cy, bx, by;
   logic [CW-1:0]       dx, dy;
   logic [THRESH_W-1:0] dev;

   // De Casteljau split at the midpoint.
   always_comb begin
      ax = mid(cur_pts[0], cur_pts[2]);
      ay = mid(cur_pts[1], cur_pts[3]);
      cx = mid(cur_pts[2], cur_pts[4]);
      cy = mid(cur_pts[3], cur_pts[5]);
      bx = mid(ax, cx);
      by = mid(ay, cy);
      lo_pts = {by, bx, ay, ax, cur_pts[1], cur_pts[0]};
      hi_pts = {cur_pts[5], cur_pts[4], cy, cx, by, bx};
   end

   // Manhattan deviation of the control point from the chord midpoint.
   always_comb begin
      dx = absdiff(cur_pts[2], mid(cur_pts[0], cur_pts[4]));
      dy = absdiff(cur_pts[3], mid(cur_pts[1], cur_pts[5]));
      dev = THRESH_W'(dx) + THRESH_W'(dy);
      flat = (dev <= threshold);
   end

endmodule

`default_nettype wire

>>> rtl/qcf_stack.sv
`timescale 1ns / 1ps
`default_nettype none

// Stack of right halves that wait for their turn. Registered read.
module qcf_stack
   import qcf_pkg::*;
#(
   parameter int DEPTH  = MAX_DEPTH_DEF,
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctrl_type          ctrl,
   input  wire logic [DATA_W-1:0] wr_data,
   output logic      [DATA_W-1:0] rd_data,
   output logic                   empty
);

   localparam int FW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [FW-1:0]     rd_idx;
   logic              full;

   assign full    = (fill_ff >= FW'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign rd_idx  = fill_ff - FW'(1);
   assign rd_data = rd_data_ff;

   // Fill count: cleared when a new curve is taken, else counted up on a push and down on a pop.
   always_comb begin
      fill_in = fill_ff;
      if (ctrl.load_in) begin
         fill_in = '0;
      end else if (ctrl.push && !full) begin
         fill_in = fill_ff + FW'(1);
      end else if (ctrl.pop && !empty) begin
         fill_in = rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Entry storage: write at the fill count, read just below it.
   always_ff @(posedge clock) begin
      if (ctrl.push && !full) begin
         mem[fill_ff[IW-1:0]] <= wr_data;
      end
      if (ctrl.pop) begin
         rd_data_ff <= mem[rd_idx[IW-1:0]];
      end
   end

endmodule

`default_nettype wire

>>> rtl/qcf_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer that drives the split unit and the pending stack.
module qcf_seq
   import qcf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic rsp_ready,
   input  wire logic do_split,
   input  wire logic stack_empty,
   output ctrl_type  ctrl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!do_split) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) state_in = stack_empty ? ST_IDLE : ST_POP;
         end
         ST_POP: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_EVAL;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            ctrl.load_in   = req_valid;
         end
         ST_EVAL: begin
            ctrl.push       = do_split;
            ctrl.load_split = do_split;
         end
         ST_EMIT: begin
            ctrl.rsp_valid = 1'b1;
         end
         ST_POP: begin
            ctrl.pop = 1'b1;
         end
         ST_LOAD: begin
            ctrl.load_pop = 1'b1;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/quadratic_curve_flattener_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake         Carries
// req_if    in         valid / ready     start, control and end point of a curve
// rsp_if    out        valid / ready     one line segment and final_segment
// csr_*     in         write enable      flatness threshold
//
// A curve yields up to 64 segments at the default depth.
// Each split and each flatness check is one pass through the single split unit;
// each waiting half passes through a pop and a load state for the stack's registered read.
// Reset clears the sequencer and the stack fill and sets the threshold to 5.
// A stall on rsp_if holds the current segment; no new curve is taken meanwhile.
`include "assert_macros.svh"

module quadratic_curve_flattener_unit
   import qcf_pkg::*;
#(
   parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   qcf_req_if.sink                  req_if,
   qcf_rsp_if.source                rsp_if,
   input  wire logic                csr_wr_en,
   input  wire logic [THRESH_W-1:0] csr_wr_data
);

   localparam int CW     = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
   localparam int LW     = $clog2(MAX_DEPTH + 1);
   localparam int PTS_W  = NUM_COORDS * CW;
   localparam int DATA_W = PTS_W + LW;

   ctrl_type                    ctrl;
   logic [THRESH_W-1:0]         threshold_ff;
   logic [NUM_COORDS-1:0][CW-1:0] cur_pts_ff, cur_pts_in;
   logic [LW-1:0]               cur_level_ff, cur_level_in;
   logic [NUM_COORDS-1:0][CW-1:0] lo_pts, hi_pts, in_pts;
   logic                        flat;
   logic                        do_split;
   logic                        stack_empty;
   logic [DATA_W-1:0]           push_data;
   logic [DATA_W-1:0]           pop_data;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   // Input curve, cut to the coordinate width.
   assign in_pts = {req_if.end_y[CW-1:0], req_if.end_x[CW-1:0],
                    req_if.control_y[CW-1:0], req_if.control_x[CW-1:0],
                    req_if.start_y[CW-1:0], req_if.start_x[CW-1:0]};

   qcf_split_unit #(
      .CW (CW)
   ) u_split (
      .cur_pts   (cur_pts_ff),
      .threshold (threshold_ff),
      .lo_pts    (lo_pts),
      .hi_pts    (hi_pts),
      .flat      (flat)
   );

   // The whole curve is always split once; deeper halves only when curved and below the depth limit.
   assign do_split = (cur_level_ff == '0) ||
                     (!flat && (cur_level_ff < LW'(MAX_DEPTH)));

   qcf_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .rsp_ready   (rsp_if.ready),
      .do_split    (do_split),
      .stack_empty (stack_empty),
      .ctrl        (ctrl)
   );

   assign push_data = {cur_level_ff + LW'(1), hi_pts};

   qcf_stack #(
      .DEPTH  (MAX_DEPTH),
      .DATA_W (DATA_W)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .wr_data (push_data),
      .rd_data (pop_data),
      .empty   (stack_empty)
   );

   // Current half: a new curve, the left half of a split, or a popped half.
   always_comb begin
      cur_pts_in   = cur_pts_ff;
      cur_level_in = cur_level_ff;
      if (ctrl.load_in) begin
         cur_pts_in   = in_pts;
         cur_level_in = '0;
      end else if (ctrl.load_split) begin
         cur_pts_in   = lo_pts;
         cur_level_in = cur_level_ff + LW'(1);
      end else if (ctrl.load_pop) begin
         cur_pts_in   = pop_data[PTS_W-1:0];
         cur_level_in = pop_data[DATA_W-1 -: LW];
      end
   end

   always_ff @(posedge clock) begin
      cur_pts_ff   <= cur_pts_in;
      cur_level_ff <= cur_level_in;
   end

   // Handshake and segment payload.
   assign req_if.ready         = ctrl.req_ready;
   assign rsp_if.valid         = ctrl.rsp_valid;
   assign rsp_if.seg_from_x    = FIELD_W'(cur_pts_ff[0]);
   assign rsp_if.seg_from_y    = FIELD_W'(cur_pts_ff[1]);
   assign rsp_if.seg_to_x      = FIELD_W'(cur_pts_ff[4]);
   assign rsp_if.seg_to_y      = FIELD_W'(cur_pts_ff[5]);
   assign rsp_if.final_segment = stack_empty;

   // A segment is never offered while a new curve can be taken.
   `ASSERT_IMPLIES(a_rsp_blocks_req, clock, reset, rsp_if.valid, !req_if.ready)

   // A new curve starts at level zero with an empty stack.
   `ASSERT_NEXT(a_start_clean, clock, reset, req_if.valid && req_if.ready,
                (cur_level_ff == '0) && stack_empty)

   // After the final segment's transfer the block is ready for the next curve.
   `ASSERT_NEXT(a_final_to_idle, clock, reset,
                rsp_if.valid && rsp_if.ready && rsp_if.final_segment, req_if.ready)

   // A half at the depth limit is never split.
   `ASSERT_IMPLIES(a_depth_limit, clock, reset, ctrl.load_split,
                   cur_level_ff < LW'(MAX_DEPTH))

endmodule

`default_nettype wire
